// File: hdl/lsrr_pkg.sv
// ----------------------------------------------------------------------------
// Least-served round-robin arbiter: shared types and codes
// Event kinds and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lsrr_pkg;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_RESET = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  typedef struct packed {
    logic capture;     // latch the accepted event
    logic scan_init;   // start a scan at the round-robin pointer
    logic scan_issue;  // read one lane and step the scan
    logic apply;       // commit the event and load the result register
  } lsrr_cmd_t;

  typedef struct packed {
    logic scan_last;   // current issue is the final lane of the scan
    logic out_free;    // result register can take a new transaction
  } lsrr_sts_t;

endpackage

// File: hdl/least_served_round_robin_arbiter.sv
// ----------------------------------------------------------------------------
// Least-served round-robin arbiter
// Grants the not-done lane with the smallest service count, ties broken
// round-robin from a rotating pointer; lane reset and lane done events.
// ----------------------------------------------------------------------------
//   channel | direction | payload
//   in_     | in        | kind, lane
//   out_    | out       | grant_valid, grant_lane, all_done
//   cfg_    | in        | schedule_enable (always ready)
//
// A tick goes from accept through the scan, with one read of the count memory
// per lane, then drain and apply. Lane reset, lane done and unused events go
// from accept straight to apply.
// One event is in flight at a time; the result register lets the next
// event be accepted while a result waits, and apply holds on out_ready.
// Synchronous reset sets every count to one via per-lane valid bits.
// ----------------------------------------------------------------------------
module least_served_round_robin_arbiter #(
  parameter int LANES       = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [3:0] in_lane,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_grant_valid,
  output logic [3:0] out_grant_lane,
  output logic       out_all_done,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_schedule_enable
);

  lsrr_pkg::lsrr_cmd_t cmd;
  lsrr_pkg::lsrr_sts_t sts;

  assign cfg_ready = 1'b1;

  lsrr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lsrr_dp #(
    .LANES       (LANES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_kind             (in_kind),
    .in_lane             (in_lane),
    .cfg_valid           (cfg_valid),
    .cfg_schedule_enable (cfg_schedule_enable),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_grant_valid     (out_grant_valid),
    .out_grant_lane      (out_grant_lane),
    .out_all_done        (out_all_done)
  );

endmodule

// File: hdl/lsrr_ctrl.sv
// ----------------------------------------------------------------------------
// Least-served round-robin arbiter: controller
// Sequences accept, lane scan, drain and apply for one event at a time.
// ----------------------------------------------------------------------------
module lsrr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_kind,
  output logic              in_ready,
  input  lsrr_pkg::lsrr_sts_t sts,
  output lsrr_pkg::lsrr_cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_APPLY = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_kind == lsrr_pkg::KIND_TICK) begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end else begin
            state_nxt = S_APPLY;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      // last read's compare lands here
      S_DRAIN: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (sts.out_free) begin
          cmd.apply = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hdl/lsrr_dp.sv
// ----------------------------------------------------------------------------
// Least-served round-robin arbiter: datapath
// Count memory, done flags, pointer, min-search compare and result register.
// ----------------------------------------------------------------------------
module lsrr_dp #(
  parameter int LANES       = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        in_kind,
  input  logic [3:0]        in_lane,
  input  logic              cfg_valid,
  input  logic              cfg_schedule_enable,
  input  lsrr_pkg::lsrr_cmd_t cmd,
  output lsrr_pkg::lsrr_sts_t sts,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_grant_valid,
  output logic [3:0]        out_grant_lane,
  output logic              out_all_done
);

  localparam int LW = $clog2(LANES);
  localparam logic [LW-1:0] LAST_LANE = LW'(LANES - 1);

  // service counts; an entry never written since reset reads as one
  logic [COUNT_WIDTH-1:0] mem [LANES];
  logic [LANES-1:0]       cnt_vld_r;
  logic [LANES-1:0]       done_r;
  logic [LANES-1:0]       done_nxt;
  logic [LW-1:0]          ptr_r;
  logic                   sched_en_r;

  logic [1:0]             kind_r;
  logic [3:0]             lane_r;

  logic [LW-1:0]          idx_r;
  logic [LW-1:0]          scan_cnt_r;
  logic [LW-1:0]          idx_d_r;
  logic                   cmp_vld_r;
  logic [COUNT_WIDTH-1:0] rd_cnt_r;
  logic                   rd_cvld_r;
  logic                   rd_done_r;
  logic [COUNT_WIDTH-1:0] rd_val;
  logic                   found_r;
  logic [COUNT_WIDTH-1:0] best_r;
  logic [LW-1:0]          best_idx_r;

  logic                   lane_ok;
  logic [LW-1:0]          lane_idx;
  logic                   do_grant;
  logic                   mem_we;
  logic [LW-1:0]          mem_wa;
  logic [COUNT_WIDTH-1:0] mem_wd;

  logic                   out_valid_r;
  logic                   grant_valid_r;
  logic [3:0]             grant_lane_r;
  logic                   all_done_r;

  assign lane_ok  = (32'(lane_r) < LANES);
  assign lane_idx = LW'(lane_r);
  assign do_grant = cmd.apply && (kind_r == lsrr_pkg::KIND_TICK) && found_r && sched_en_r;
  assign rd_val   = rd_cvld_r ? rd_cnt_r : COUNT_WIDTH'(1);

  assign sts.scan_last = (scan_cnt_r == LAST_LANE);
  assign sts.out_free  = !out_valid_r || out_ready;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = best_idx_r;
    mem_wd = (best_r == '1) ? best_r : best_r + COUNT_WIDTH'(1);
    if (do_grant) begin
      mem_we = 1'b1;
    end else if (cmd.apply && (kind_r == lsrr_pkg::KIND_RESET) && lane_ok) begin
      mem_we = 1'b1;
      mem_wa = lane_idx;
      mem_wd = '0;
    end
  end

  always_comb begin
    done_nxt = done_r;
    if (cmd.apply && lane_ok) begin
      if (kind_r == lsrr_pkg::KIND_RESET) begin
        done_nxt[lane_idx] = 1'b0;
      end else if (kind_r == lsrr_pkg::KIND_DONE) begin
        done_nxt[lane_idx] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_cnt_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r   <= '0;
      done_r      <= '0;
      ptr_r       <= '0;
      sched_en_r  <= 1'b1;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        sched_en_r <= cfg_schedule_enable;
      end
      if (mem_we) begin
        cnt_vld_r[mem_wa] <= 1'b1;
      end
      done_r    <= done_nxt;
      cmp_vld_r <= cmd.scan_issue;
      if (do_grant) begin
        ptr_r <= (best_idx_r == LAST_LANE) ? '0 : best_idx_r + LW'(1);
      end
      // scanning from the pointer with a strict compare keeps the
      // first least-served lane in round-robin order
      if (cmd.scan_init) begin
        found_r <= 1'b0;
      end else if (cmp_vld_r && !rd_done_r && (!found_r || rd_val < best_r)) begin
        found_r <= 1'b1;
      end
      if (cmd.apply) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      lane_r <= in_lane;
    end
    if (cmd.scan_init) begin
      idx_r      <= ptr_r;
      scan_cnt_r <= '0;
    end else if (cmd.scan_issue) begin
      idx_r      <= (idx_r == LAST_LANE) ? '0 : idx_r + LW'(1);
      scan_cnt_r <= scan_cnt_r + LW'(1);
    end
    idx_d_r   <= idx_r;
    rd_cvld_r <= cnt_vld_r[idx_r];
    rd_done_r <= done_r[idx_r];
    if (cmp_vld_r && !rd_done_r && (!found_r || rd_val < best_r)) begin
      best_r     <= rd_val;
      best_idx_r <= idx_d_r;
    end
    if (cmd.apply) begin
      grant_valid_r <= do_grant;
      grant_lane_r  <= do_grant ? 4'(best_idx_r) : 4'd0;
      all_done_r    <= &done_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_grant_valid = grant_valid_r;
  assign out_grant_lane  = grant_lane_r;
  assign out_all_done    = all_done_r;

endmodule
